>>> rtl/lcdns_pkg.sv
// Package for the character LCD nibble sequencer.
// Holds request codes, payload and queue types, register reset values and the row table.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lcdns_pkg;

	// Request codes carried by the cmd field.
	localparam logic [2:0] REQ_IDLE  = 3'd0;
	localparam logic [2:0] REQ_INIT  = 3'd1;
	localparam logic [2:0] REQ_CMD   = 3'd2;
	localparam logic [2:0] REQ_DATA  = 3'd3;
	localparam logic [2:0] REQ_GOTO  = 3'd4;
	localparam logic [2:0] REQ_AREA  = 3'd5;
	localparam logic [2:0] REQ_CLEAR = 3'd6;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ENTRY_MODE   = 2'd0;
	localparam logic [1:0] CFG_FUNCTION_SET = 2'd1;
	localparam logic [1:0] CFG_DISPLAY_CTRL = 2'd2;
	localparam logic [1:0] CFG_CLEAR_DISP   = 2'd3;

	// Register reset values.
	localparam logic [7:0] ENTRY_MODE_RESET   = 8'h02;
	localparam logic [7:0] FUNCTION_SET_RESET = 8'h28;
	localparam logic [7:0] DISPLAY_CTRL_RESET = 8'h0C;
	localparam logic [7:0] CLEAR_DISP_RESET   = 8'h01;

	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// One request as it arrives.
	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] byte_value;
		logic [2:0] row;
		logic [4:0] col;
		logic [6:0] count;
	} req_t;

	// Pin levels and status reported for each request.
	typedef struct packed {
		logic       pins_enabled;
		logic       reg_select;
		logic       read_write;
		logic       enable_pin;
		logic [3:0] data_nibble;
		logic       busy_res;
		logic       done_res;
	} res_t;

	// Classified request held in the queue between front and back.
	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] value;
		logic [6:0] count;
	} entry_t;

	// Configuration register file contents.
	typedef struct packed {
		logic [7:0] entry_mode;
		logic [7:0] function_set;
		logic [7:0] display_ctrl;
		logic [7:0] clear_disp;
	} cfg_t;

	// DDRAM base address of each display row, indexed by row minus one.
	function automatic logic [7:0] row_base(input logic [1:0] idx);
		logic [7:0] base;
		case (idx)
			2'd0:    base = 8'h80;
			2'd1:    base = 8'hC0;
			2'd2:    base = 8'h94;
			default: base = 8'hD4;
		endcase
		return base;
	endfunction

endpackage

`default_nettype wire

>>> rtl/char_lcd_nibble_sequencer.sv
// Top level of the character LCD nibble sequencer: configuration registers,
// front end with request queue, and the pin sequencing back end. Depends on lcdns_pkg.
//
// Each request item is one sequencer tick and yields exactly one result with the
// LCD pin levels after that tick. A new item is taken every cycle unless the queue is
// full, and the back end advances one step per queued item, one per cycle unless a
// waiting result is stalled; each item sits in the QUEUE_DEPTH-entry queue between
// front and back end, then in the result register, which lets the next item proceed
// only while it is empty or its result is taken. Requests other than a plain tick
// start only when the sequencer is idle; while one runs, further codes count as ticks.
// A byte takes eight ticks, init takes 33, a cursor move eight, clear area nine plus
// eight per space. Configuration is written through cfg_write_en, cfg_index and
// cfg_data; the user must do so only while the block is idle, as nothing enforces it.
`default_nettype none

module char_lcd_nibble_sequencer #(
	parameter int QUEUE_DEPTH = lcdns_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_stall,
	input  lcdns_pkg::req_t  req_data,
	output logic             res_valid,
	input  wire              res_stall,
	output lcdns_pkg::res_t  res_data,
	input  wire              cfg_write_en,
	input  wire [1:0]        cfg_index,
	input  wire [7:0]        cfg_data
);

	lcdns_pkg::cfg_t   cfg_q;
	lcdns_pkg::entry_t q_entry;
	logic              q_valid;
	logic              q_pop;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entry_mode   <= lcdns_pkg::ENTRY_MODE_RESET;
			cfg_q.function_set <= lcdns_pkg::FUNCTION_SET_RESET;
			cfg_q.display_ctrl <= lcdns_pkg::DISPLAY_CTRL_RESET;
			cfg_q.clear_disp   <= lcdns_pkg::CLEAR_DISP_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				lcdns_pkg::CFG_ENTRY_MODE:   cfg_q.entry_mode   <= cfg_data;
				lcdns_pkg::CFG_FUNCTION_SET: cfg_q.function_set <= cfg_data;
				lcdns_pkg::CFG_DISPLAY_CTRL: cfg_q.display_ctrl <= cfg_data;
				default:                     cfg_q.clear_disp   <= cfg_data;
			endcase
		end
	end

	lcdns_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop)
	);

	lcdns_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	// A finishing tick never reports busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_data.done_res && res_data.busy_res))
		else $error("done and busy reported together");

	// The strobe is only high in the middle of a running request.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.enable_pin |-> res_data.busy_res)
		else $error("enable strobe high while idle");

	// The back end only takes an entry that the queue holds.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// Once the pins are outputs they stay so.
	a_pins_stay: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && res_data.pins_enabled ##1 res_valid
		|-> res_data.pins_enabled)
		else $error("pins_enabled dropped");

endmodule

`default_nettype wire

>>> rtl/lcdns_front.sv
// Front end of the LCD sequencer: classifies incoming requests and queues them.
// Computes the cursor address for move requests. Depends on lcdns_pkg.
`default_nettype none

module lcdns_front #(
	parameter int QUEUE_DEPTH = lcdns_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_stall,
	input  lcdns_pkg::req_t      req_data,
	output logic                 q_valid,
	output lcdns_pkg::entry_t    q_entry,
	input  wire                  q_pop
);

	localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

	lcdns_pkg::entry_t entry_c;
	lcdns_pkg::entry_t mem_q [QUEUE_DEPTH];
	logic [IdxW-1:0] wr_ptr_q;
	logic [IdxW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic [7:0] addr_c;
	logic push;

	// Cursor address: row table entry plus column minus one, wrapping at 256.
	assign addr_c = lcdns_pkg::row_base(req_data.row[1:0] - 2'd1)
		+ {3'b000, req_data.col} + 8'hFF;

	// Classify the request; a code without meaning becomes a plain tick.
	always_comb begin
		entry_c.cmd   = req_data.cmd;
		entry_c.value = 8'h00;
		entry_c.count = req_data.count;
		unique case (req_data.cmd) inside
			lcdns_pkg::REQ_CMD, lcdns_pkg::REQ_DATA: begin
				entry_c.value = req_data.byte_value;
			end
			lcdns_pkg::REQ_GOTO, lcdns_pkg::REQ_AREA: begin
				entry_c.value = addr_c;
			end
			lcdns_pkg::REQ_IDLE, lcdns_pkg::REQ_INIT, lcdns_pkg::REQ_CLEAR: begin
			end
			default: begin
				entry_c.cmd = lcdns_pkg::REQ_IDLE;
			end
		endcase
	end

	assign req_stall = (count_q == FullCnt);
	assign push      = req_valid && !req_stall;
	assign q_valid   = (count_q != '0);
	assign q_entry   = mem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry_c;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/lcdns_back.sv
// Back end of the LCD sequencer: runs one tick of the pin sequence per queued request.
// Holds the request state machine and the registered result. Depends on lcdns_pkg.
`default_nettype none

module lcdns_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  q_valid,
	input  lcdns_pkg::entry_t    q_entry,
	output logic                 q_pop,
	input  lcdns_pkg::cfg_t      cfg,
	output logic                 res_valid,
	input  wire                  res_stall,
	output lcdns_pkg::res_t      res_data
);

	logic [2:0] phase_q, phase_n;
	logic [2:0] req_q, req_n;
	logic [2:0] init_q, init_n;
	logic [7:0] latch_q, latch_n;
	logic [6:0] spaces_q, spaces_n;
	logic       area_q, area_n;
	logic       rs_q, rs_n;
	logic       e_q, e_n;
	logic [3:0] nib_q, nib_n;
	logic       on_q, on_n;
	logic       do_tick, tick_rs, byte_done, finished;
	logic       res_valid_q;
	lcdns_pkg::res_t res_q;

	assign q_pop = q_valid && (!res_valid_q || !res_stall);

	// Init command selected by the current init step.
	function automatic logic [7:0] init_cmd(input lcdns_pkg::cfg_t c, input logic [1:0] sel);
		logic [7:0] v;
		case (sel)
			lcdns_pkg::CFG_ENTRY_MODE:   v = c.entry_mode;
			lcdns_pkg::CFG_FUNCTION_SET: v = c.function_set;
			lcdns_pkg::CFG_DISPLAY_CTRL: v = c.display_ctrl;
			default:                     v = c.clear_disp;
		endcase
		return v;
	endfunction

	// Next state for one tick.
	always_comb begin
		phase_n   = phase_q;
		req_n     = req_q;
		init_n    = init_q;
		latch_n   = latch_q;
		spaces_n  = spaces_q;
		area_n    = area_q;
		rs_n      = rs_q;
		e_n       = e_q;
		nib_n     = nib_q;
		on_n      = on_q;
		do_tick   = 1'b0;
		tick_rs   = 1'b0;
		byte_done = 1'b0;
		finished  = 1'b0;

		// Start a new request only while idle.
		if (req_q == lcdns_pkg::REQ_IDLE && q_entry.cmd != lcdns_pkg::REQ_IDLE) begin
			req_n   = q_entry.cmd;
			phase_n = 3'd0;
			unique case (q_entry.cmd) inside
				lcdns_pkg::REQ_INIT: init_n = 3'd0;
				lcdns_pkg::REQ_CMD, lcdns_pkg::REQ_DATA, lcdns_pkg::REQ_GOTO: begin
					latch_n = q_entry.value;
				end
				lcdns_pkg::REQ_AREA: begin
					latch_n  = q_entry.value;
					spaces_n = q_entry.count;
					area_n   = 1'b0;
				end
				default: latch_n = cfg.clear_disp;
			endcase
		end

		// Decide what this tick does for the running request.
		unique case (req_n) inside
			lcdns_pkg::REQ_IDLE: begin
			end
			lcdns_pkg::REQ_INIT: begin
				if (init_n == 3'd0) begin
					on_n   = 1'b1;
					init_n = 3'd1;
				end else begin
					if (phase_n == 3'd0) begin
						latch_n = init_cmd(cfg, init_n[1:0] - 2'd1);
					end
					do_tick = 1'b1;
				end
			end
			lcdns_pkg::REQ_DATA: begin
				do_tick = 1'b1;
				tick_rs = 1'b1;
			end
			lcdns_pkg::REQ_AREA: begin
				if (!area_n) begin
					do_tick = 1'b1;
				end else if (spaces_n == 7'd0) begin
					area_n   = 1'b0;
					finished = 1'b1;
				end else begin
					if (phase_n == 3'd0) begin
						latch_n = lcdns_pkg::SPACE_CHAR;
					end
					do_tick = 1'b1;
					tick_rs = 1'b1;
				end
			end
			lcdns_pkg::REQ_CMD, lcdns_pkg::REQ_GOTO, lcdns_pkg::REQ_CLEAR: begin
				do_tick = 1'b1;
			end
			default: finished = 1'b1;
		endcase

		// Eight-phase byte pattern on the bus pins.
		if (do_tick) begin
			case (phase_n)
				3'd0: rs_n = tick_rs;
				3'd1: e_n = 1'b1;
				3'd2: nib_n = latch_n[7:4];
				3'd3: e_n = 1'b0;
				3'd4: e_n = 1'b1;
				3'd5: nib_n = latch_n[3:0];
				3'd6: e_n = 1'b0;
				default: byte_done = 1'b1;
			endcase
			phase_n = byte_done ? 3'd0 : phase_n + 3'd1;
		end

		// Follow-up once a whole byte has gone out.
		if (byte_done) begin
			unique case (req_n) inside
				lcdns_pkg::REQ_INIT: begin
					if (init_n >= 3'd4) begin
						init_n   = 3'd0;
						finished = 1'b1;
					end else begin
						init_n = init_n + 3'd1;
					end
				end
				lcdns_pkg::REQ_AREA: begin
					if (!area_n) begin
						area_n = 1'b1;
					end else begin
						spaces_n = spaces_n - 7'd1;
					end
				end
				default: finished = 1'b1;
			endcase
		end

		if (finished) begin
			req_n = lcdns_pkg::REQ_IDLE;
		end
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 3'd0;
			req_q    <= lcdns_pkg::REQ_IDLE;
			init_q   <= 3'd0;
			latch_q  <= 8'h00;
			spaces_q <= 7'd0;
			area_q   <= 1'b0;
			rs_q     <= 1'b0;
			e_q      <= 1'b0;
			nib_q    <= 4'h0;
			on_q     <= 1'b0;
		end else if (q_pop) begin
			phase_q  <= phase_n;
			req_q    <= req_n;
			init_q   <= init_n;
			latch_q  <= latch_n;
			spaces_q <= spaces_n;
			area_q   <= area_n;
			rs_q     <= rs_n;
			e_q      <= e_n;
			nib_q    <= nib_n;
			on_q     <= on_n;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (q_pop) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload: pin levels after this tick.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q.pins_enabled <= on_n;
			res_q.reg_select   <= rs_n;
			res_q.read_write   <= 1'b0;
			res_q.enable_pin   <= e_n;
			res_q.data_nibble  <= nib_n;
			res_q.busy_res     <= (req_n != lcdns_pkg::REQ_IDLE);
			res_q.done_res     <= finished;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

`default_nettype wire

>>> tb/char_lcd_nibble_sequencer_tb.sv
// Self-checking testbench for the character LCD nibble sequencer.
// A scoreboard class predicts the pin levels of every tick and checks each result.
// Depends on lcdns_pkg and char_lcd_nibble_sequencer.
`timescale 1ns / 100ps

module char_lcd_nibble_sequencer_tb;

	// The cmd code that has no meaning and counts as a plain tick.
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	// Cycles to wait after the last result before a register write or the verdict.
	localparam int SETTLE_CYCLES = lcdns_pkg::QUEUE_DEPTH_DEFAULT + 12;
	localparam int RANDOM_ITEMS_PER_PHASE = 90;

	// Predicts the pin levels after each tick and matches them to the results.
	class lcd_pin_scoreboard;
		logic [7:0] regs [4];
		logic [2:0] active;
		logic [2:0] phase;
		logic [2:0] step;
		logic [7:0] latch;
		logic [6:0] spaces;
		bit         spaces_due;
		bit         rs_q;
		bit         e_q;
		logic [3:0] nib_q;
		bit         pins_on;
		lcdns_pkg::res_t pending_pins [$];
		int         errors;

		function new();
			regs[lcdns_pkg::CFG_ENTRY_MODE]   = lcdns_pkg::ENTRY_MODE_RESET;
			regs[lcdns_pkg::CFG_FUNCTION_SET] = lcdns_pkg::FUNCTION_SET_RESET;
			regs[lcdns_pkg::CFG_DISPLAY_CTRL] = lcdns_pkg::DISPLAY_CTRL_RESET;
			regs[lcdns_pkg::CFG_CLEAR_DISP]   = lcdns_pkg::CLEAR_DISP_RESET;
			active = lcdns_pkg::REQ_IDLE;
			phase = '0;
			step = '0;
			latch = '0;
			spaces = '0;
			spaces_due = 0;
			rs_q = 0;
			e_q = 0;
			nib_q = '0;
			pins_on = 0;
			errors = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [7:0] val);
			regs[idx] = val;
		endfunction

		function bit busy();
			return active != lcdns_pkg::REQ_IDLE;
		endfunction

		function int pending_count();
			return pending_pins.size();
		endfunction

		// DDRAM address for a one based row and column; rows wrap modulo four.
		function logic [7:0] cursor_addr(logic [2:0] row, logic [4:0] col);
			logic [1:0] idx;
			logic [7:0] base;
			idx = row[1:0] + 2'd3;
			case (idx)
				2'd0: base = 8'h80;
				2'd1: base = 8'hC0;
				2'd2: base = 8'h94;
				default: base = 8'hD4;
			endcase
			return base + {3'b000, col} + 8'hFF;
		endfunction

		// One step of the eight-tick byte pattern; returns 1 on the finishing tick.
		function bit byte_step(bit rs);
			case (phase)
				3'd0: rs_q = rs;
				3'd1: e_q = 1;
				3'd2: nib_q = latch[7:4];
				3'd3: e_q = 0;
				3'd4: e_q = 1;
				3'd5: nib_q = latch[3:0];
				3'd6: e_q = 0;
				default: begin
					phase = '0;
					return 1;
				end
			endcase
			phase = phase + 3'd1;
			return 0;
		endfunction

		// Advance the prediction by one accepted request and queue the expected pins.
		function void note_request(lcdns_pkg::req_t r);
			bit   fin;
			lcdns_pkg::res_t exp_pins;
			fin = 0;
			if (active == lcdns_pkg::REQ_IDLE && r.cmd >= lcdns_pkg::REQ_INIT
					&& r.cmd <= lcdns_pkg::REQ_CLEAR) begin
				active = r.cmd;
				phase = '0;
				case (r.cmd)
					lcdns_pkg::REQ_INIT: step = '0;
					lcdns_pkg::REQ_CMD, lcdns_pkg::REQ_DATA: latch = r.byte_value;
					lcdns_pkg::REQ_GOTO: latch = cursor_addr(r.row, r.col);
					lcdns_pkg::REQ_AREA: begin
						latch = cursor_addr(r.row, r.col);
						spaces = r.count;
						spaces_due = 0;
					end
					default: latch = regs[lcdns_pkg::CFG_CLEAR_DISP];
				endcase
			end

			case (active)
				lcdns_pkg::REQ_IDLE: ;
				lcdns_pkg::REQ_INIT: begin
					if (step == 3'd0) begin
						pins_on = 1;
						step = 3'd1;
					end else begin
						// Each init command is taken from its register at the start of its byte.
						if (phase == 3'd0)
							latch = regs[2'(step - 3'd1)];
						if (byte_step(0)) begin
							if (step >= 3'd4) begin
								step = '0;
								fin = 1;
							end else begin
								step = step + 3'd1;
							end
						end
					end
				end
				lcdns_pkg::REQ_DATA: fin = byte_step(1);
				lcdns_pkg::REQ_AREA: begin
					// Cursor move first, then the spaces, then one closing tick.
					if (!spaces_due) begin
						if (byte_step(0))
							spaces_due = 1;
					end else if (spaces == '0) begin
						spaces_due = 0;
						fin = 1;
					end else begin
						if (phase == 3'd0)
							latch = lcdns_pkg::SPACE_CHAR;
						if (byte_step(1))
							spaces = spaces - 7'd1;
					end
				end
				lcdns_pkg::REQ_CMD, lcdns_pkg::REQ_GOTO, lcdns_pkg::REQ_CLEAR:
					fin = byte_step(0);
				default: fin = 1;
			endcase

			if (fin)
				active = lcdns_pkg::REQ_IDLE;

			exp_pins.pins_enabled = pins_on;
			exp_pins.reg_select = rs_q;
			exp_pins.read_write = 1'b0;
			exp_pins.enable_pin = e_q;
			exp_pins.data_nibble = nib_q;
			exp_pins.busy_res = (active != lcdns_pkg::REQ_IDLE);
			exp_pins.done_res = fin;
			pending_pins.push_back(exp_pins);
		endfunction

		function void report_field(string field, int exp_val, int act_val);
			errors++;
			if (errors <= 10)
				$display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, field,
					exp_val, act_val);
		endfunction

		// Compare one accepted result with the oldest expectation.
		function void check_result(lcdns_pkg::res_t act);
			lcdns_pkg::res_t exp_pins;
			if (pending_pins.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result %0h arrived with nothing expected", $realtime, act);
				return;
			end
			exp_pins = pending_pins.pop_front();
			if (act.pins_enabled !== exp_pins.pins_enabled)
				report_field("pins_enabled", exp_pins.pins_enabled, act.pins_enabled);
			if (act.reg_select !== exp_pins.reg_select)
				report_field("reg_select", exp_pins.reg_select, act.reg_select);
			if (act.read_write !== exp_pins.read_write)
				report_field("read_write", exp_pins.read_write, act.read_write);
			if (act.enable_pin !== exp_pins.enable_pin)
				report_field("enable_pin", exp_pins.enable_pin, act.enable_pin);
			if (act.data_nibble !== exp_pins.data_nibble)
				report_field("data_nibble", exp_pins.data_nibble, act.data_nibble);
			if (act.busy_res !== exp_pins.busy_res)
				report_field("busy_res", exp_pins.busy_res, act.busy_res);
			if (act.done_res !== exp_pins.done_res)
				report_field("done_res", exp_pins.done_res, act.done_res);
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            req_valid = 1'b0;
	logic            req_stall;
	lcdns_pkg::req_t req_data = '0;
	logic            res_valid;
	logic            res_stall = 1'b0;
	lcdns_pkg::res_t res_data;
	logic            cfg_write_en = 1'b0;
	logic [1:0]      cfg_index = lcdns_pkg::CFG_ENTRY_MODE;
	logic [7:0]      cfg_data = '0;

	lcd_pin_scoreboard sb;
	bit calm = 0;
	int stall_left = 0;
	int big_areas = 0;

	char_lcd_nibble_sequencer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 8 ns clock.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Mostly short gaps, a few long ones, none while calm.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side: check accepted results, then choose the next stall level.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(res_data);
		if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else begin
			stall_left = pick_gap();
			res_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Present one request and hold it until the block takes it.
	task automatic send_item(lcdns_pkg::req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		forever begin
			@(posedge clk);
			if (!req_stall)
				break;
		end
		sb.note_request(r);
	endtask

	// Fully random fields; while a request runs these only count as ticks.
	function automatic lcdns_pkg::req_t noise_item();
		lcdns_pkg::req_t r;
		r.cmd = 3'($urandom);
		r.byte_value = 8'($urandom);
		r.row = 3'($urandom);
		r.col = 5'($urandom);
		r.count = 7'($urandom);
		return r;
	endfunction

	// A request for an idle sequencer, weighted toward well-formed fields.
	function automatic lcdns_pkg::req_t make_request();
		lcdns_pkg::req_t r;
		int pick;
		r = noise_item();
		pick = $urandom_range(0, 99);
		if (pick < 10)
			r.cmd = lcdns_pkg::REQ_INIT;
		else if (pick < 30)
			r.cmd = lcdns_pkg::REQ_CMD;
		else if (pick < 55)
			r.cmd = lcdns_pkg::REQ_DATA;
		else if (pick < 70)
			r.cmd = lcdns_pkg::REQ_GOTO;
		else if (pick < 85)
			r.cmd = lcdns_pkg::REQ_AREA;
		else if (pick < 93)
			r.cmd = lcdns_pkg::REQ_CLEAR;
		else if (pick < 97)
			r.cmd = lcdns_pkg::REQ_IDLE;
		else
			r.cmd = CMD_UNUSED;
		if ($urandom_range(0, 9) != 0) begin
			r.row = 3'($urandom_range(1, 4));
			r.col = 5'($urandom_range(1, 20));
		end
		// Clear area mostly writes a few spaces; a rare one writes many.
		if (r.cmd == lcdns_pkg::REQ_AREA && big_areas < 1 && $urandom_range(0, 29) == 0) begin
			r.count = 7'($urandom_range(40, 80));
			big_areas++;
		end else begin
			r.count = 7'($urandom_range(0, 5));
		end
		return r;
	endfunction

	// Send one request, then noise ticks until the sequencer is idle again.
	task automatic run_request(logic [2:0] cmd, logic [7:0] val, logic [2:0] row,
			logic [4:0] col, logic [6:0] count);
		lcdns_pkg::req_t r;
		r.cmd = cmd;
		r.byte_value = val;
		r.row = row;
		r.col = col;
		r.count = count;
		send_item(r);
		while (sb.busy())
			send_item(noise_item());
	endtask

	// Finish the running request and wait until every result has been taken.
	task automatic settle();
		while (sb.busy())
			send_item(noise_item());
		req_valid <= 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_register(idx, val);
	endtask

	task automatic write_all(logic [7:0] v0, logic [7:0] v1, logic [7:0] v2, logic [7:0] v3);
		write_reg(lcdns_pkg::CFG_ENTRY_MODE, v0);
		write_reg(lcdns_pkg::CFG_FUNCTION_SET, v1);
		write_reg(lcdns_pkg::CFG_DISPLAY_CTRL, v2);
		write_reg(lcdns_pkg::CFG_CLEAR_DISP, v3);
		cfg_write_en <= 1'b0;
	endtask

	task automatic run_random(int n);
		int sent;
		sent = 0;
		while (sent < n) begin
			if (sb.busy())
				send_item(noise_item());
			else
				send_item(make_request());
			sent++;
		end
	endtask

	// Main sequence: reset, directed requests, then randomized phases.
	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests, with reset register values.
		run_request(lcdns_pkg::REQ_IDLE, 8'h00, 3'd1, 5'd1, 7'd0);
		run_request(CMD_UNUSED, 8'hFF, 3'd7, 5'd31, 7'd127);
		run_request(lcdns_pkg::REQ_INIT, 8'h00, 3'd1, 5'd1, 7'd0);
		run_request(lcdns_pkg::REQ_CMD, 8'h00, 3'd1, 5'd1, 7'd0);
		run_request(lcdns_pkg::REQ_CMD, 8'hFF, 3'd1, 5'd1, 7'd0);
		run_request(lcdns_pkg::REQ_DATA, 8'hA5, 3'd1, 5'd1, 7'd0);
		run_request(lcdns_pkg::REQ_DATA, 8'h5A, 3'd1, 5'd1, 7'd0);
		run_request(lcdns_pkg::REQ_GOTO, 8'h00, 3'd1, 5'd1, 7'd0);
		run_request(lcdns_pkg::REQ_GOTO, 8'h00, 3'd2, 5'd20, 7'd0);
		run_request(lcdns_pkg::REQ_GOTO, 8'h00, 3'd3, 5'd1, 7'd0);
		run_request(lcdns_pkg::REQ_GOTO, 8'h00, 3'd4, 5'd20, 7'd0);
		// Rows outside one to four wrap; column zero and 31 fall outside the row.
		run_request(lcdns_pkg::REQ_GOTO, 8'h00, 3'd0, 5'd0, 7'd0);
		run_request(lcdns_pkg::REQ_GOTO, 8'h00, 3'd5, 5'd31, 7'd0);
		run_request(lcdns_pkg::REQ_GOTO, 8'h00, 3'd7, 5'd31, 7'd0);
		run_request(lcdns_pkg::REQ_AREA, 8'h00, 3'd2, 5'd5, 7'd0);
		run_request(lcdns_pkg::REQ_AREA, 8'h00, 3'd3, 5'd7, 7'd1);
		run_request(lcdns_pkg::REQ_AREA, 8'h00, 3'd4, 5'd20, 7'd4);
		run_request(lcdns_pkg::REQ_CLEAR, 8'h00, 3'd1, 5'd1, 7'd0);
		settle();

		// Register settings: all clear, all set, random, then back to reset values.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: write_all(8'h00, 8'h00, 8'h00, 8'h00);
				1: write_all(8'hFF, 8'hFF, 8'hFF, 8'hFF);
				2: write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				default: write_all(lcdns_pkg::ENTRY_MODE_RESET,
					lcdns_pkg::FUNCTION_SET_RESET, lcdns_pkg::DISPLAY_CTRL_RESET,
					lcdns_pkg::CLEAR_DISP_RESET);
			endcase
			calm = (p == 2);
			run_request(lcdns_pkg::REQ_INIT, 8'h00, 3'd1, 5'd1, 7'd0);
			run_request(lcdns_pkg::REQ_CLEAR, 8'h00, 3'd1, 5'd1, 7'd0);
			run_random(RANDOM_ITEMS_PER_PHASE);
			settle();
		end

		if (sb.errors == 0)
			$display("char_lcd_nibble_sequencer regression: pass");
		else
			$display("char_lcd_nibble_sequencer regression: fail");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20_000_000;
		$display("char_lcd_nibble_sequencer regression: fail");
		$finish;
	end

endmodule

>>> char_lcd_nibble_sequencer.f
rtl/lcdns_pkg.sv
rtl/lcdns_front.sv
rtl/lcdns_back.sv
rtl/char_lcd_nibble_sequencer.sv
tb/char_lcd_nibble_sequencer_tb.sv
